@@ rtl/core/frame_difference_morph_mask_unit_macros.svh @@
// Assertion macros for the frame difference morphology mask unit.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef FRAME_DIFFERENCE_MORPH_MASK_UNIT_MACROS_SVH
`define FRAME_DIFFERENCE_MORPH_MASK_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FDMM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fdmm: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FDMM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fdmm: assertion failed");

`endif

@@ rtl/core/fdmm_pkg.sv @@
// Shared types and constants of the frame difference morphology mask unit.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package fdmm_pkg;

	localparam int DEF_MAX_WIDTH     = 1024;
	localparam int DEF_MAX_HEIGHT    = 4096;
	localparam int DEF_ERODE_RADIUS  = 3;
	localparam int DEF_DILATE_RADIUS = 7;

	localparam int PIX_W        = 8;
	localparam int LABEL_W      = 8;
	localparam int THR_W        = 8;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 2;

	localparam logic [THR_W-1:0]        THR_RESET    = 8'd30;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd512;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd512;

	localparam int OUT_FIFO_DEPTH = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DIFF_THRESHOLD = 2'd0,
		CFG_IMAGE_WIDTH    = 2'd1,
		CFG_IMAGE_HEIGHT   = 2'd2
	} cfg_index_t;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_FLUSH = 1'b1
	} command_t;

	typedef struct packed {
		logic [LABEL_W-1:0] prev_label;
		logic [PIX_W-1:0]   cur_pixel;
		logic [PIX_W-1:0]   prev_pixel;
	} in_beat_t;

	localparam int IN_DATA_W = $bits(in_beat_t);

endpackage

@@ rtl/core/fdmm_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fdmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/frame_difference_morph_mask_unit.sv @@
// Frame difference change mask with square erosion and dilation, label masking.
// Throughput: one beat per cycle while s_tready is high; a result leaves the output queue after
// the beat that completes its windows (ERODE_RADIUS+DILATE_RADIUS rows and pixels later in
// raster order). At frame end, when width*height is below that lag, the unit runs idle positions
// on its own up to the lag before flush beats are taken. Column stores and labels use fdmm_ram.
// Reset is asynchronous: registers return to defaults, positions to zero; memories keep contents.
`timescale 1ns / 1ps
`include "frame_difference_morph_mask_unit_macros.svh"

module frame_difference_morph_mask_unit #(
	parameter int MAX_WIDTH     = fdmm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT    = fdmm_pkg::DEF_MAX_HEIGHT,
	parameter int ERODE_RADIUS  = fdmm_pkg::DEF_ERODE_RADIUS,
	parameter int DILATE_RADIUS = fdmm_pkg::DEF_DILATE_RADIUS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// prev_pixel [7:0], cur_pixel [15:8], prev_label [23:16]
	input  logic [fdmm_pkg::IN_DATA_W-1:0]   s_tdata,
	// command [0]
	input  logic [0:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// new_label [7:0]
	output logic [fdmm_pkg::LABEL_W-1:0]     m_tdata,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [fdmm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fdmm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	import fdmm_pkg::*;

	localparam int ER       = ERODE_RADIUS;
	localparam int DR       = DILATE_RADIUS;
	localparam int ECNT     = 2 * ER;
	localparam int DCNT     = 2 * DR;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT + ER + DR + 2);
	localparam int LAG_MAX  = (ER + DR) * (MAX_WIDTH + 1);
	localparam int POS_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + LAG_MAX + 1);
	localparam int LB_AW    = $clog2(LAG_MAX + 1);
	localparam int LB_DEPTH = 1 << LB_AW;
	localparam int AREA_W   = WIDTH_REG_W + HEIGHT_REG_W;
	localparam int FCNT_W   = $clog2(OUT_FIFO_DEPTH + 1);
	localparam int FPTR_W   = $clog2(OUT_FIFO_DEPTH);

	// Configuration registers.
	logic [THR_W-1:0]        thr_q;
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic                    drv_ok_q;
	logic                    restart_cfg;

	assign restart_cfg = cfg_we && (cfg_index == CFG_IMAGE_WIDTH ||
		cfg_index == CFG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			drv_ok_q <= 1'b0;
		end else begin
			drv_ok_q <= !cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					CFG_DIFF_THRESHOLD: thr_q <= cfg_wdata[THR_W-1:0];
					CFG_IMAGE_WIDTH: width_q <= cfg_wdata[WIDTH_REG_W-1:0];
					CFG_IMAGE_HEIGHT: height_q <= cfg_wdata[HEIGHT_REG_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Frame geometry derived from the size registers.
	logic [WIDTH_REG_W-1:0]  w_lim;
	logic [HEIGHT_REG_W-1:0] h_lim;
	logic [AREA_W-1:0]       area;
	logic [COL_W-1:0]        wm1_q;
	logic [ROW_W-1:0]        hlim_q;
	logic [POS_W-1:0]        total_q;
	logic [POS_W-1:0]        totm1_q;
	logic [POS_W-1:0]        le_q;
	logic [POS_W-1:0]        lag_q;

	always_comb begin
		if (width_q == '0) begin
			w_lim = WIDTH_REG_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_lim = WIDTH_REG_W'(MAX_WIDTH);
		end else begin
			w_lim = width_q;
		end
		if (height_q == '0) begin
			h_lim = HEIGHT_REG_W'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_lim = HEIGHT_REG_W'(MAX_HEIGHT);
		end else begin
			h_lim = height_q;
		end
		area = AREA_W'(w_lim) * AREA_W'(h_lim);
	end

	always_ff @(posedge clk) begin
		wm1_q   <= COL_W'(w_lim - 1'b1);
		hlim_q  <= ROW_W'(h_lim);
		total_q <= POS_W'(area);
		totm1_q <= POS_W'(area - 1'b1);
		le_q    <= POS_W'(ER * 32'(w_lim) + ER);
		lag_q   <= POS_W'((ER + DR) * 32'(w_lim) + ER + DR);
	end

	// Position counters.
	logic [POS_W-1:0] vlin_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] qc_q;
	logic [ROW_W-1:0] qr_q;
	logic [POS_W-1:0] plin_q;
	logic [COL_W-1:0] pc_q;

	// Issue stage.
	in_beat_t          beat;
	logic              pix_phase;
	logic              auto_pad;
	logic              credit_ok;
	logic              acc;
	logic              pix_tick;
	logic              tick;
	logic              qact0;
	logic              prod0;
	logic              eof0;
	logic              chg0;
	logic [PIX_W-1:0]  diff0;
	logic [ECNT-1:0]   erow0;
	logic [DCNT-1:0]   drow0;
	logic [ECNT:0]     emask0;
	logic [DCNT:0]     dmask0;
	logic              qin0;
	logic [2:0]        inflight;
	logic [FCNT_W:0]   occupancy;
	logic [FCNT_W-1:0] fifo_cnt_q;

	// Pipeline registers.
	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic               prod_s1, prod_s2, prod_s3, prod_s4;
	logic               eof_s1, eof_s2, eof_s3, eof_s4;
	logic               qact_s1, qact_s2, qact_s3;
	logic               chg_s1;
	logic [COL_W-1:0]   col_s1;
	logic [ECNT-1:0]    erow_s1;
	logic [COL_W-1:0]   qc_s1, qc_s2, qc_s3;
	logic               qin_s1, qin_s2;
	logic [DCNT-1:0]    drow_s1, drow_s2, drow_s3;
	logic [ECNT:0]      emask_s1, emask_s2;
	logic [DCNT:0]      dmask_s1, dmask_s2, dmask_s3, dmask_s4;
	logic               cfwd_s1;
	logic [ECNT-1:0]    cfwdv_s1;
	logic [LABEL_W-1:0] label_s2, label_s3, label_s4;
	logic               ero_s3;
	logic               efwd_s3;
	logic [DCNT-1:0]    efwdv_s3;

	assign beat      = in_beat_t'(s_tdata);
	assign pix_phase = vlin_q < total_q;
	assign auto_pad  = !pix_phase && (vlin_q < lag_q);
	assign inflight  = 3'(valid_s1 && prod_s1) + 3'(valid_s2 && prod_s2) +
		3'(valid_s3 && prod_s3) + 3'(valid_s4 && prod_s4);
	assign occupancy = (FCNT_W + 1)'(fifo_cnt_q) + (FCNT_W + 1)'(inflight);
	assign credit_ok = occupancy < (FCNT_W + 1)'(OUT_FIFO_DEPTH);
	assign s_tready  = drv_ok_q && credit_ok && !auto_pad;
	assign acc       = s_tvalid && s_tready;
	assign pix_tick  = acc && pix_phase && (s_tuser != CMD_FLUSH);
	assign tick      = pix_tick || (acc && !pix_phase) || (drv_ok_q && auto_pad);
	assign qact0     = vlin_q >= le_q;
	assign prod0     = vlin_q >= lag_q;
	assign eof0      = prod0 && (plin_q == totm1_q);
	assign qin0      = qr_q < hlim_q;
	assign diff0     = (beat.prev_pixel > beat.cur_pixel) ?
		beat.prev_pixel - beat.cur_pixel : beat.cur_pixel - beat.prev_pixel;
	assign chg0      = pix_tick ? (diff0 > thr_q) : 1'b1;

	always_comb begin
		for (int k = 1; k <= ECNT; k++) begin
			erow0[k-1] = 32'(row_q) >= 32'(k);
		end
		for (int k = 1; k <= DCNT; k++) begin
			drow0[k-1] = 32'(qr_q) >= 32'(k);
		end
		for (int k = 0; k <= ECNT; k++) begin
			emask0[k] = (32'(qc_q) + ER >= 32'(k)) && (32'(qc_q) + ER <= 32'(wm1_q) + 32'(k));
		end
		for (int k = 0; k <= DCNT; k++) begin
			dmask0[k] = (32'(pc_q) + DR >= 32'(k)) && (32'(pc_q) + DR <= 32'(wm1_q) + 32'(k));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlin_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
			qc_q   <= '0;
			qr_q   <= '0;
			plin_q <= '0;
			pc_q   <= '0;
		end else if (restart_cfg || (tick && eof0)) begin
			vlin_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
			qc_q   <= '0;
			qr_q   <= '0;
			plin_q <= '0;
			pc_q   <= '0;
		end else if (tick) begin
			vlin_q <= vlin_q + 1'b1;
			if (col_q == wm1_q) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
			if (qact0) begin
				if (qc_q == wm1_q) begin
					qc_q <= '0;
					qr_q <= qr_q + 1'b1;
				end else begin
					qc_q <= qc_q + 1'b1;
				end
			end
			if (prod0) begin
				plin_q <= plin_q + 1'b1;
				if (pc_q == wm1_q) begin
					pc_q <= '0;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

	// Memories.
	logic [ECNT-1:0]    chg_rdata;
	logic [ECNT-1:0]    cvec;
	logic [ECNT-1:0]    cwr;
	logic               vand;
	logic [DCNT-1:0]    ero_rdata;
	logic [DCNT-1:0]    evec;
	logic [DCNT-1:0]    ewr;
	logic               vor;
	logic [LABEL_W-1:0] lbl_rdata;
	logic               ero2;
	logic               efwd2;
	logic [ECNT:0]      hreg_q;
	logic [DCNT:0]      dreg_q;

	fdmm_ram #(.WIDTH(ECNT), .DEPTH(MAX_WIDTH)) u_chg_ram (
		.clk(clk), .we(valid_s1), .waddr(col_s1), .wdata(cwr),
		.re(tick), .raddr(col_q), .rdata(chg_rdata)
	);

	fdmm_ram #(.WIDTH(DCNT), .DEPTH(MAX_WIDTH)) u_ero_ram (
		.clk(clk), .we(valid_s3 && qact_s3), .waddr(qc_s3), .wdata(ewr),
		.re(valid_s2 && qact_s2), .raddr(qc_s2), .rdata(ero_rdata)
	);

	fdmm_ram #(.WIDTH(LABEL_W), .DEPTH(LB_DEPTH)) u_lbl_ram (
		.clk(clk), .we(pix_tick), .waddr(vlin_q[LB_AW-1:0]), .wdata(beat.prev_label),
		.re(tick), .raddr(plin_q[LB_AW-1:0]), .rdata(lbl_rdata)
	);

	// Stage 1: vertical erosion over the column history.
	assign cvec = cfwd_s1 ? cfwdv_s1 : chg_rdata;
	assign vand = chg_s1 & (&(cvec | ~erow_s1));
	assign cwr  = {cvec[ECNT-2:0], chg_s1};

	// Stage 2: horizontal erosion.
	assign ero2  = qin_s2 & (&(hreg_q | ~emask_s2));
	assign efwd2 = valid_s3 && qact_s3 && (qc_s3 == qc_s2);

	// Stage 3: vertical dilation over the eroded column history.
	assign evec = efwd_s3 ? efwdv_s3 : ero_rdata;
	assign vor  = ero_s3 | (|(evec & drow_s3));
	assign ewr  = {evec[DCNT-2:0], ero_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= tick;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= prod0;
		eof_s1   <= eof0;
		qact_s1  <= qact0;
		chg_s1   <= chg0;
		col_s1   <= col_q;
		erow_s1  <= erow0;
		qc_s1    <= qc_q;
		qin_s1   <= qin0;
		drow_s1  <= drow0;
		emask_s1 <= emask0;
		dmask_s1 <= dmask0;
		cfwd_s1  <= valid_s1 && (col_s1 == col_q);
		cfwdv_s1 <= cwr;

		prod_s2  <= prod_s1;
		eof_s2   <= eof_s1;
		qact_s2  <= qact_s1;
		qc_s2    <= qc_s1;
		qin_s2   <= qin_s1;
		drow_s2  <= drow_s1;
		emask_s2 <= emask_s1;
		dmask_s2 <= dmask_s1;
		label_s2 <= lbl_rdata;

		prod_s3  <= prod_s2;
		eof_s3   <= eof_s2;
		qact_s3  <= qact_s2;
		qc_s3    <= qc_s2;
		ero_s3   <= ero2;
		drow_s3  <= drow_s2;
		dmask_s3 <= dmask_s2;
		label_s3 <= label_s2;
		efwd_s3  <= efwd2;
		efwdv_s3 <= ewr;

		prod_s4  <= prod_s3;
		eof_s4   <= eof_s3;
		dmask_s4 <= dmask_s3;
		label_s4 <= label_s3;

		if (valid_s1) begin
			hreg_q <= {hreg_q[ECNT-1:0], vand};
		end
		if (valid_s3 && qact_s3) begin
			dreg_q <= {dreg_q[DCNT-1:0], vor};
		end
	end

	// Stage 4: horizontal dilation, label select and output queue.
	logic               push;
	logic               pop;
	logic               dil;
	logic [FPTR_W-1:0]  wptr_q;
	logic [FPTR_W-1:0]  rptr_q;
	logic [LABEL_W-1:0] fifo_lbl_q [OUT_FIFO_DEPTH];
	logic               fifo_eof_q [OUT_FIFO_DEPTH];

	assign dil  = |(dreg_q & dmask_s4);
	assign push = valid_s4 && prod_s4;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_cnt_q <= '0;
			wptr_q     <= '0;
			rptr_q     <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == FPTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == FPTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				fifo_cnt_q <= fifo_cnt_q + 1'b1;
			end else if (pop && !push) begin
				fifo_cnt_q <= fifo_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_lbl_q[wptr_q] <= dil ? '0 : label_s4;
			fifo_eof_q[wptr_q] <= eof_s4;
		end
	end

	assign m_tvalid = fifo_cnt_q != '0;
	assign m_tdata  = fifo_lbl_q[rptr_q];
	assign m_tlast  = fifo_eof_q[rptr_q];

	`FDMM_ASSERT_IMP(a_occupancy_bound, 1'b1, occupancy <= (FCNT_W + 1)'(OUT_FIFO_DEPTH))
	`FDMM_ASSERT_IMP(a_result_in_frame, tick && prod0, plin_q < total_q)
	`FDMM_ASSERT_NXT(a_frame_restart, tick && eof0, vlin_q == '0 && plin_q == '0)

endmodule
